/* sv/ptsp_pkg.sv */
`default_nettype none

package ptsp_pkg;

    // Field widths of the channels.
    localparam int PULSE_W     = 11;
    localparam int DEG_W       = 8;
    localparam int TILT_W      = 7;
    localparam int CFG_IDX_W   = 3;

    // Item kinds.
    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Tilt commands carried by a controller message.
    localparam logic [1:0] TILT_UP   = 2'd0;
    localparam logic [1:0] TILT_DOWN = 2'd1;
    localparam logic [1:0] TILT_WAVE = 2'd2;
    localparam logic [1:0] TILT_HOLD = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_MAX = 3'd3;

    // Register reset values.
    localparam logic [PULSE_W-1:0] PAN_MIN_RESET  = 11'd32;
    localparam logic [PULSE_W-1:0] PAN_MAX_RESET  = 11'd270;
    localparam logic [PULSE_W-1:0] TILT_MIN_RESET = 11'd50;
    localparam logic [PULSE_W-1:0] TILT_MAX_RESET = 11'd250;

    // Tilt limits and reset positions.
    localparam logic [TILT_W-1:0] TILT_HIGH  = 7'd110;
    localparam logic [TILT_W-1:0] TILT_LOW   = 7'd70;
    localparam logic [TILT_W-1:0] TILT_RESET = 7'd90;
    localparam logic [DEG_W-1:0]  PAN_RESET  = 8'd90;

    // Smoothing factor 6554/65536 with rounding away from zero.
    localparam int               ALPHA_W     = 13;
    localparam logic [ALPHA_W-1:0] ALPHA_NUM = 13'd6554;
    localparam int               ALPHA_SHIFT = 16;
    localparam logic [ALPHA_SHIFT-1:0] ALPHA_ROUND = 16'hFFFF;

    // Division by 180 as multiplication by ceil(2^28 / 180), exact for
    // dividends below 2^19.
    localparam int               DIVIDEND_W  = 19;
    localparam int               RECIP_W     = 21;
    localparam int               RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_180 = 21'd1491309;
    localparam int               QUOT_W      = 12;

    localparam logic [PULSE_W-1:0] PULSE_LIMIT = 11'd2000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_MUL,
        ST_STEP_APPLY,
        ST_PAN_MUL,
        ST_PAN_DIV,
        ST_TILT_MUL,
        ST_TILT_DIV,
        ST_DONE
    } ptsp_state_t;

    // Tilt state as updated by a controller message.
    typedef struct packed {
        logic [TILT_W-1:0] position;
        logic              wave_up;
    } ptsp_tilt_t;

endpackage

`default_nettype wire

/* sv/ptsp_if.sv */
`default_nettype none

// Input item channel.
interface ptsp_in_if import ptsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [DEG_W-1:0] pan_target;
    logic [1:0]       tilt_command;

    modport source (output valid, command, pan_target, tilt_command, input ready);
    modport sink   (input valid, command, pan_target, tilt_command, output ready);
endinterface

// Result item channel.
interface ptsp_out_if import ptsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pan_pulse;
    logic [PULSE_W-1:0] tilt_pulse;

    modport source (output valid, pan_pulse, tilt_pulse, input ready);
    modport sink   (input valid, pan_pulse, tilt_pulse, output ready);
endinterface

// Configuration write channel.
interface ptsp_cfg_if import ptsp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PULSE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/ptsp_mul.sv */
`default_nettype none

module ptsp_mul #(
    parameter int A_W = 24,
    parameter int B_W = 21
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0]      prod_reg
);

    logic [A_W+B_W-1:0] prod_next;

    // Full-width unsigned product of the selected operands.
    always_comb
    begin
        prod_next = {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};
    end

    // The product is registered before anything else uses it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ptsp_tilt.sv */
`default_nettype none

module ptsp_tilt import ptsp_pkg::*; (
    input  wire logic [TILT_W-1:0] position,
    input  wire logic              wave_up,
    input  wire logic [1:0]        tilt_command,
    output ptsp_tilt_t             tilt_next
);

    logic [TILT_W-1:0] stepped;

    // One wave step in the current direction.
    always_comb
    begin
        stepped = wave_up ? position + 7'd1 : position - 7'd1;
    end

    // Apply the tilt command; up and down stop at their limits, a wave step
    // reverses once it reaches either limit.
    always_comb
    begin
        tilt_next.position = position;
        tilt_next.wave_up  = wave_up;
        unique case (tilt_command)
            TILT_UP:
            begin
                if (position < TILT_HIGH)
                begin
                    tilt_next.position = position + 7'd1;
                end
            end
            TILT_DOWN:
            begin
                if (position > TILT_LOW)
                begin
                    tilt_next.position = position - 7'd1;
                end
            end
            TILT_WAVE:
            begin
                tilt_next.position = stepped;
                if (stepped >= TILT_HIGH || stepped <= TILT_LOW)
                begin
                    tilt_next.wave_up = ~wave_up;
                end
            end
            TILT_HOLD:
            begin
                tilt_next.position = position;
            end
            default:
            begin
                tilt_next.position = position;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/pan_tilt_servo_pwm_controller_unit.sv */
// A controller message is taken only while the sequencer is idle and gives no result.
// A tick runs STEP_MUL, STEP_APPLY, PAN_MUL, PAN_DIV, TILT_MUL, TILT_DIV and DONE,
// where its result enters the output register; the five products it needs go one
// after another through one shared multiplier, and no item is taken until idle again.
// A waiting result stops the input only once a second tick has finished behind it.
// Reset (asynchronous, active low) restores pan 90.0, goal 90, tilt 90, wave up.
`default_nettype none

module pan_tilt_servo_pwm_controller_unit import ptsp_pkg::*; #(
    parameter int POSITION_FRAC_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptsp_in_if.sink     item,
    ptsp_out_if.source  result,
    ptsp_cfg_if.sink    cfg
);

    localparam int POS_W   = 8 + POSITION_FRAC_BITS;
    localparam int MUL_A_W = (POS_W > DIVIDEND_W) ? POS_W : DIVIDEND_W;
    localparam int MUL_B_W = RECIP_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    ptsp_state_t state_reg, state_next;

    logic [PULSE_W-1:0] pan_min_reg, pan_max_reg, tilt_min_reg, tilt_max_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [DEG_W-1:0]   goal_reg;
    logic [TILT_W-1:0]  tilt_reg;
    logic               wave_up_reg;
    logic               step_down_reg;
    logic [PULSE_W-1:0] pan_res_reg;
    logic               out_valid_reg;
    logic [PULSE_W-1:0] out_pan_reg, out_tilt_reg;

    logic               item_fire;
    logic               cfg_fire;
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;
    logic               load_out;
    ptsp_tilt_t         tilt_next;

    logic [POS_W-1:0]   goal_fx;
    logic               goal_below;
    logic [POS_W-1:0]   mag;
    logic [PROD_W:0]    round_sum;
    logic [POS_W-1:0]   step;
    logic [POS_W-1:0]   pos_next;
    logic [PULSE_W:0]   pan_diff, tilt_diff;
    logic               pan_neg, tilt_neg;
    logic [PULSE_W-1:0] pan_span, tilt_span;
    logic [QUOT_W-1:0]  quot;

    // Saturated pulse width from the lower bound and the signed quotient.
    function automatic logic [PULSE_W-1:0] pulse_finish(
        input logic [PULSE_W-1:0] lo,
        input logic [QUOT_W-1:0]  q,
        input logic               neg
    );
        logic signed [QUOT_W+1:0] qs;
        logic signed [QUOT_W+1:0] v;
        qs = $signed({2'b00, q});
        v  = $signed({3'b000, lo}) + (neg ? -qs : qs);
        if (v < 0)
        begin
            return '0;
        end
        else if (v > $signed({3'b000, PULSE_LIMIT}))
        begin
            return PULSE_LIMIT;
        end
        else
        begin
            return v[PULSE_W-1:0];
        end
    endfunction

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.pan_pulse  = out_pan_reg;
    assign result.tilt_pulse = out_tilt_reg;

    // Smoothing step: distance to goal and the rounded-up tenth of it.
    always_comb
    begin
        goal_fx    = {goal_reg, {POSITION_FRAC_BITS{1'b0}}};
        goal_below = goal_fx < pos_reg;
        mag        = goal_below ? pos_reg - goal_fx : goal_fx - pos_reg;
        round_sum  = {1'b0, prod_reg} + (PROD_W + 1)'(ALPHA_ROUND);
        step       = round_sum[ALPHA_SHIFT +: POS_W];
        pos_next   = step_down_reg ? pos_reg - step : pos_reg + step;
    end

    // Spans between the pulse bounds, as sign and magnitude.
    always_comb
    begin
        pan_diff  = {1'b0, pan_max_reg} - {1'b0, pan_min_reg};
        tilt_diff = {1'b0, tilt_max_reg} - {1'b0, tilt_min_reg};
        pan_neg   = pan_diff[PULSE_W];
        tilt_neg  = tilt_diff[PULSE_W];
        pan_span  = pan_neg ? PULSE_W'(-pan_diff) : pan_diff[PULSE_W-1:0];
        tilt_span = tilt_neg ? PULSE_W'(-tilt_diff) : tilt_diff[PULSE_W-1:0];
        quot      = prod_reg[RECIP_SHIFT +: QUOT_W];
    end

    ptsp_tilt u_tilt (
        .position     (tilt_reg),
        .wave_up      (wave_up_reg),
        .tilt_command (item.tilt_command),
        .tilt_next    (tilt_next)
    );

    ptsp_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && item.command == CMD_TICK)
                begin
                    state_next = ST_STEP_MUL;
                end
            end
            ST_STEP_MUL:   state_next = ST_STEP_APPLY;
            ST_STEP_APPLY: state_next = ST_PAN_MUL;
            ST_PAN_MUL:    state_next = ST_PAN_DIV;
            ST_PAN_DIV:    state_next = ST_TILT_MUL;
            ST_TILT_MUL:   state_next = ST_TILT_DIV;
            ST_TILT_DIV:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operand selection and strobes.
    always_comb
    begin
        item.ready = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            ST_STEP_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(mag);
                mul_b  = MUL_B_W'(ALPHA_NUM);
            end
            ST_PAN_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(pos_reg[POS_W-1:POSITION_FRAC_BITS]);
                mul_b  = MUL_B_W'(pan_span);
            end
            ST_PAN_DIV, ST_TILT_DIV:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(prod_reg[DIVIDEND_W-1:0]);
                mul_b  = RECIP_180;
            end
            ST_TILT_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(tilt_reg);
                mul_b  = MUL_B_W'(tilt_span);
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || result.ready;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_min_reg  <= PAN_MIN_RESET;
            pan_max_reg  <= PAN_MAX_RESET;
            tilt_min_reg <= TILT_MIN_RESET;
            tilt_max_reg <= TILT_MAX_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_PAN_MIN:  pan_min_reg  <= cfg.data;
                REG_PAN_MAX:  pan_max_reg  <= cfg.data;
                REG_TILT_MIN: tilt_min_reg <= cfg.data;
                REG_TILT_MAX: tilt_max_reg <= cfg.data;
                default:      pan_min_reg  <= pan_min_reg;
            endcase
        end
    end

    // Servo state: messages update goal and tilt, a tick moves pan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= {PAN_RESET, {POSITION_FRAC_BITS{1'b0}}};
            goal_reg      <= PAN_RESET;
            tilt_reg      <= TILT_RESET;
            wave_up_reg   <= 1'b1;
            step_down_reg <= 1'b0;
        end
        else
        begin
            if (item_fire && item.command == CMD_MESSAGE)
            begin
                goal_reg    <= item.pan_target;
                tilt_reg    <= tilt_next.position;
                wave_up_reg <= tilt_next.wave_up;
            end
            if (state_reg == ST_STEP_MUL)
            begin
                step_down_reg <= goal_below;
            end
            if (state_reg == ST_STEP_APPLY)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Pan pulse is finished while the tilt product is formed.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TILT_MUL)
        begin
            pan_res_reg <= pulse_finish(pan_min_reg, quot, pan_neg);
        end
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pan_reg  <= pan_res_reg;
            out_tilt_reg <= pulse_finish(tilt_min_reg, quot, tilt_neg);
        end
    end

    // A tick transfer always starts the smoothing multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.command == CMD_TICK |=> state_reg == ST_STEP_MUL)
        else $error("tick did not start the sequence");

    // Tilt never leaves the band that a wave step can reach.
    assert property (@(posedge clk) disable iff (!rst_n)
        tilt_reg >= 7'd69 && tilt_reg <= 7'd111)
        else $error("tilt position out of range");

    // A smoothing step never carries the pan position past its goal.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP_APPLY |=>
            (step_down_reg ? pos_reg >= goal_fx : pos_reg <= goal_fx))
        else $error("pan position overshot its goal");

    // A result appears only at the end of the sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

endmodule

`default_nettype wire

/* verif/ptsp_checker.sv */
`timescale 1ns / 1ps

// Watches the item, result and register channels of the pan/tilt pulse unit,
// predicts every pulse pair from its own copy of the state and compares each
// result transfer with the oldest prediction.
module ptsp_checker import ptsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    ptsp_in_if   item,
    ptsp_out_if  result,
    ptsp_cfg_if  cfg,
    output int   fail_count,
    output int   pending,
    output int   pulses_seen
);

    // Smoothing factor and tilt travel limits of the servo mount.
    localparam longint unsigned SMOOTH_NUM   = 6554;
    localparam longint unsigned SMOOTH_ROUND = 65535;
    localparam int              SMOOTH_SHIFT = 16;
    localparam int              TILT_CEIL    = 110;
    localparam int              TILT_FLOOR   = 70;
    localparam int              SPAN_DEGREES = 180;
    localparam longint          WIDTH_LIMIT  = 2000;
    localparam logic [63:0]     POS_MASK     = (64'd1 << (DEG_W + FRAC_BITS)) - 64'd1;

    typedef struct packed {
        logic [PULSE_W-1:0] pan;
        logic [PULSE_W-1:0] tilt;
    } pulse_pair_t;

    pulse_pair_t        pulse_queue[$];
    logic [PULSE_W-1:0] pan_min, pan_max, tilt_min, tilt_max;
    logic [63:0]        pan_pos;
    logic [DEG_W-1:0]   pan_goal;
    int                 tilt_pos;
    logic               wave_up;

    // Linear map of an angle onto a pulse range, truncating, then clamped.
    function automatic logic [PULSE_W-1:0] pulse_width(input longint angle,
                                                      input logic [PULSE_W-1:0] lo,
                                                      input logic [PULSE_W-1:0] hi);
        longint lo_v;
        longint hi_v;
        longint v;
        lo_v = lo;
        hi_v = hi;
        v = lo_v + angle * (hi_v - lo_v) / SPAN_DEGREES;
        if (v < 0)
            v = 0;
        if (v > WIDTH_LIMIT)
            v = WIDTH_LIMIT;
        return v[PULSE_W-1:0];
    endfunction

    // A controller message sets the pan goal and nudges the tilt axis.
    task automatic apply_message(input logic [DEG_W-1:0] goal_deg,
                                 input logic [1:0] tilt_cmd);
        pan_goal = goal_deg;
        case (tilt_cmd)
            TILT_UP:
            begin
                if (tilt_pos < TILT_CEIL)
                    tilt_pos = tilt_pos + 1;
            end
            TILT_DOWN:
            begin
                if (tilt_pos > TILT_FLOOR)
                    tilt_pos = tilt_pos - 1;
            end
            TILT_WAVE:
            begin
                tilt_pos = wave_up ? tilt_pos + 1 : tilt_pos - 1;
                if (tilt_pos >= TILT_CEIL || tilt_pos <= TILT_FLOOR)
                    wave_up = !wave_up;
            end
            default:
            begin
            end
        endcase
        tilt_pos = tilt_pos & 'h7F;
    endtask

    // A tick moves pan a tenth of the way to its goal, rounding the step away
    // from zero, and yields both pulse widths.
    task automatic apply_tick(output pulse_pair_t widths);
        logic [63:0] goal_fx;
        logic [63:0] gap;
        logic [63:0] stride;
        goal_fx = 64'(pan_goal) << FRAC_BITS;
        if (goal_fx >= pan_pos)
        begin
            gap = goal_fx - pan_pos;
            stride = (gap * SMOOTH_NUM + SMOOTH_ROUND) >> SMOOTH_SHIFT;
            pan_pos = pan_pos + stride;
        end
        else
        begin
            gap = pan_pos - goal_fx;
            stride = (gap * SMOOTH_NUM + SMOOTH_ROUND) >> SMOOTH_SHIFT;
            pan_pos = pan_pos - stride;
        end
        pan_pos = pan_pos & POS_MASK;
        widths.pan  = pulse_width(longint'(pan_pos >> FRAC_BITS), pan_min, pan_max);
        widths.tilt = pulse_width(longint'(tilt_pos), tilt_min, tilt_max);
    endtask

    // Observe all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        pulse_pair_t want;
        pulse_pair_t fresh;
        if (!rst_n)
        begin
            pulse_queue.delete();
            pan_min     = PAN_MIN_RESET;
            pan_max     = PAN_MAX_RESET;
            tilt_min    = TILT_MIN_RESET;
            tilt_max    = TILT_MAX_RESET;
            pan_pos     = 64'(PAN_RESET) << FRAC_BITS;
            pan_goal    = PAN_RESET;
            tilt_pos    = TILT_RESET;
            wave_up     = 1'b1;
            fail_count  = 0;
            pending     = 0;
            pulses_seen = 0;
        end
        else
        begin
            // Register writes; indexes outside the map are dropped.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PAN_MIN:  pan_min  = cfg.data;
                    REG_PAN_MAX:  pan_max  = cfg.data;
                    REG_TILT_MIN: tilt_min = cfg.data;
                    REG_TILT_MAX: tilt_max = cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            // Compare each result transfer with the oldest prediction.
            if (result.valid && result.ready)
            begin
                pulses_seen++;
                if (pulse_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, actual pan %0d tilt %0d",
                             $time, result.pan_pulse, result.tilt_pulse);
                end
                else
                begin
                    want = pulse_queue.pop_front();
                    if (result.pan_pulse !== want.pan)
                    begin
                        fail_count++;
                        $display("%0t: pan pulse mismatch, expected %0d, actual %0d",
                                 $time, want.pan, result.pan_pulse);
                    end
                    if (result.tilt_pulse !== want.tilt)
                    begin
                        fail_count++;
                        $display("%0t: tilt pulse mismatch, expected %0d, actual %0d",
                                 $time, want.tilt, result.tilt_pulse);
                    end
                end
            end

            // Predict from each item transfer.
            if (item.valid && item.ready)
            begin
                if (item.command == CMD_TICK)
                begin
                    apply_tick(fresh);
                    pulse_queue.push_back(fresh);
                end
                else
                begin
                    apply_message(item.pan_target, item.tilt_command);
                end
            end
            pending = pulse_queue.size();
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench import ptsp_pkg::*; ();

    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 190;
    localparam int IDLE_PERCENT  = 37;
    localparam int FIRST_UNMAPPED = 4;
    localparam int LAST_UNMAPPED  = 7;

    // Register settings visited, one per phase.
    typedef enum int {
        SET_FULL_SPAN,
        SET_REVERSED,
        SET_OVER_LIMIT,
        SET_RANDOM,
        SET_NARROW,
        SET_DEFAULT
    } range_setting_t;

    logic clk;
    logic rst_n;
    logic calm;
    int   hold_reqs;
    int   holds_done;
    int   hold_left;
    int   items_sent;
    int   ticks_sent;
    int   settings_used;
    int   chk_failures;
    int   chk_pending;
    int   chk_pulses;

    ptsp_in_if  item_ch ();
    ptsp_out_if res_ch ();
    ptsp_cfg_if cfg_ch ();

    pan_tilt_servo_pwm_controller_unit #(
        .POSITION_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    ptsp_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (res_ch),
        .cfg         (cfg_ch),
        .fail_count  (chk_failures),
        .pending     (chk_pending),
        .pulses_seen (chk_pulses)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus long hold-offs on request.
    initial
    begin
        res_ch.ready = 1'b0;
        holds_done   = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_done)
            begin
                holds_done = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(99) < IDLE_PERCENT)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Offer one item and wait for its transfer; returns at a falling edge.
    task automatic send_item(input logic cmd, input logic [DEG_W-1:0] goal_deg,
                             input logic [1:0] tilt_cmd);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(4, 1);
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= cmd;
        item_ch.pan_target   <= goal_deg;
        item_ch.tilt_command <= tilt_cmd;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
        items_sent++;
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, DEG_W'($urandom_range(255)), 2'($urandom_range(3)));
    endtask

    // Register write; the caller lowers valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PULSE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering items until every pulse pair has come back and the
    // sequencer has had time to finish.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input range_setting_t setting);
        logic [PULSE_W-1:0] base;
        base = PULSE_W'($urandom_range(2000));
        case (setting)
            SET_FULL_SPAN:
            begin
                write_reg(REG_PAN_MIN, 11'd0);
                write_reg(REG_PAN_MAX, 11'd2000);
                write_reg(REG_TILT_MIN, 11'd0);
                write_reg(REG_TILT_MAX, 11'd2000);
            end
            SET_REVERSED:
            begin
                write_reg(REG_PAN_MIN, 11'd2000);
                write_reg(REG_PAN_MAX, 11'd0);
                write_reg(REG_TILT_MIN, 11'd2000);
                write_reg(REG_TILT_MAX, 11'd0);
            end
            SET_OVER_LIMIT:
            begin
                write_reg(REG_PAN_MIN, 11'h7FF);
                write_reg(REG_PAN_MAX, 11'h7FF);
                write_reg(REG_TILT_MIN, 11'h7FF);
                write_reg(REG_TILT_MAX, 11'd0);
                write_reg(CFG_IDX_W'($urandom_range(LAST_UNMAPPED, FIRST_UNMAPPED)),
                          PULSE_W'($urandom_range(2047)));
            end
            SET_RANDOM:
            begin
                write_reg(REG_PAN_MIN, PULSE_W'($urandom_range(2047)));
                write_reg(REG_PAN_MAX, PULSE_W'($urandom_range(2047)));
                write_reg(REG_TILT_MIN, PULSE_W'($urandom_range(2047)));
                write_reg(REG_TILT_MAX, PULSE_W'($urandom_range(2047)));
                write_reg(CFG_IDX_W'($urandom_range(LAST_UNMAPPED, FIRST_UNMAPPED)),
                          PULSE_W'($urandom_range(2047)));
            end
            SET_NARROW:
            begin
                write_reg(REG_PAN_MIN, base);
                write_reg(REG_PAN_MAX, base + PULSE_W'($urandom_range(3)));
                write_reg(REG_TILT_MIN, base + PULSE_W'($urandom_range(40)));
                write_reg(REG_TILT_MAX, base);
            end
            default:
            begin
                write_reg(REG_PAN_MIN, PAN_MIN_RESET);
                write_reg(REG_PAN_MAX, PAN_MAX_RESET);
                write_reg(REG_TILT_MIN, TILT_MIN_RESET);
                write_reg(REG_TILT_MAX, TILT_MAX_RESET);
            end
        endcase
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Goal angles lean on the edges of the range now and then.
    function automatic logic [DEG_W-1:0] pick_goal();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd180;
            2:       return 8'd255;
            default: return DEG_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly steady stretches: one goal and one tilt command repeated among
    // ticks, so pan settles and tilt reaches its stops; some pure noise.
    task automatic run_phase(input int n_items);
        int                 start;
        int                 len;
        int                 kind;
        logic [DEG_W-1:0]   goal_deg;
        logic [1:0]         tilt_cmd;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            kind     = $urandom_range(99);
            goal_deg = pick_goal();
            tilt_cmd = 2'($urandom_range(3));
            if (kind < 65)
            begin
                len = $urandom_range(60, 10);
                repeat (len)
                begin
                    if ($urandom_range(99) < 65)
                        send_tick();
                    else
                        send_item(CMD_MESSAGE, goal_deg, tilt_cmd);
                end
            end
            else if (kind < 80)
            begin
                // A run of messages sweeps tilt against its stops.
                len = $urandom_range(45, 20);
                repeat (len) send_item(CMD_MESSAGE, goal_deg, tilt_cmd);
                repeat ($urandom_range(4, 1)) send_tick();
            end
            else
            begin
                len = $urandom_range(20, 5);
                repeat (len)
                    send_item(1'($urandom_range(1)), DEG_W'($urandom_range(255)),
                              2'($urandom_range(3)));
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n                = 1'b0;
        calm                 = 1'b0;
        hold_reqs            = 0;
        items_sent           = 0;
        ticks_sent           = 0;
        settings_used        = 0;
        item_ch.valid        = 1'b0;
        item_ch.command      = CMD_MESSAGE;
        item_ch.pan_target   = '0;
        item_ch.tilt_command = TILT_HOLD;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_PAN_MIN;
        cfg_ch.data          = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items under the reset register values.
        send_item(CMD_TICK, 8'd0, TILT_HOLD);
        send_item(CMD_MESSAGE, 8'd180, TILT_UP);
        send_item(CMD_TICK, 8'd255, TILT_UP);
        send_item(CMD_MESSAGE, 8'd0, TILT_DOWN);
        send_item(CMD_TICK, 8'd0, TILT_DOWN);
        send_item(CMD_MESSAGE, 8'd255, TILT_WAVE);
        send_item(CMD_TICK, 8'd0, TILT_WAVE);
        send_item(CMD_TICK, 8'd0, TILT_HOLD);
        send_item(CMD_MESSAGE, 8'd128, TILT_HOLD);
        send_item(CMD_TICK, 8'd0, TILT_HOLD);
        send_item(CMD_MESSAGE, 8'd127, TILT_UP);
        send_item(CMD_TICK, 8'd0, TILT_HOLD);
        send_item(CMD_MESSAGE, 8'h55, TILT_WAVE);
        send_item(CMD_TICK, 8'hAA, TILT_WAVE);
        send_item(CMD_MESSAGE, 8'hAA, TILT_DOWN);
        send_item(CMD_TICK, 8'h55, TILT_HOLD);
        send_item(CMD_MESSAGE, 8'd90, TILT_HOLD);
        send_item(CMD_TICK, 8'd0, TILT_HOLD);

        // Random phases, each under its own register setting.
        for (int p = SET_FULL_SPAN; p <= SET_DEFAULT; p++)
        begin
            drain();
            configure(range_setting_t'(p));
            if (range_setting_t'(p) == SET_OVER_LIMIT)
            begin
                // No idling on either side, and a long output stall early on.
                calm = 1'b1;
                hold_reqs++;
                repeat (40) send_tick();
            end
            run_phase(PHASE_ITEMS);
            calm = 1'b0;
        end

        drain();
        $display("Sent %0d items, %0d of them ticks; %0d pulse pairs checked.",
                 items_sent, ticks_sent, chk_pulses);
        $display("Register settings applied after reset: %0d.", settings_used);
        if (chk_failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/ptsp_pkg.sv
sv/ptsp_if.sv
sv/ptsp_mul.sv
sv/ptsp_tilt.sv
sv/pan_tilt_servo_pwm_controller_unit.sv
verif/ptsp_checker.sv
verif/testbench.sv
